### rtl/core/nldt_pkg.sv
// Shared types, codes and defaults for the length-prefixed unit deframer.
// No dependencies; all other files but nldt_ram refer to it by scoped names.
package nldt_pkg;

  // Parameter defaults and register reset value
  localparam int          TAG_DEPTH_DEF = 16;
  localparam int          TAG_WIDTH_DEF = 32;
  localparam logic [31:0] MAX_LEN_RST   = 32'd1048576;  // 1024 * 1024

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TAG_DROP = 3'd1;
  localparam logic [2:0] ST_OVERSIZE = 3'd2;
  localparam logic [2:0] ST_NO_TAG   = 3'd3;
  localparam logic [2:0] ST_DISCARD  = 3'd4;

  // Request kinds handed from front to back
  localparam logic [1:0] KIND_BYTE = 2'd0;  // pass byte result as is
  localparam logic [1:0] KIND_POP  = 2'd1;  // byte result that takes a tag
  localparam logic [1:0] KIND_PUSH = 2'd2;  // push a tag into the queue

  // Unit type field and picture type ranges
  localparam logic [7:0] TYPE_MASK      = 8'h7e;
  localparam logic [5:0] PIC_LOW_END    = 6'd9;
  localparam logic [5:0] PIC_HIGH_START = 6'd16;
  localparam logic [5:0] PIC_HIGH_END   = 6'd21;

  typedef struct packed {
    logic [1:0]  kind;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        first_of_unit;
    logic        last_of_unit;
    logic [31:0] unit_length;
    logic [5:0]  unit_type;
    logic [2:0]  status;
  } req_t;

  function automatic logic is_picture(input logic [5:0] t);
    return (t <= PIC_LOW_END) || ((t >= PIC_HIGH_START) && (t <= PIC_HIGH_END));
  endfunction

endpackage

### rtl/core/nal_length_deframer_with_tags_top.sv
// Path: an accepted request passes the queue, then the result register, which drives out_.
// Throughput: one request per cycle when out_ready holds, bytes and tag pushes alike;
//   the front-end parser update and one tag push or pop per cycle in the back end set it.
// Reset: rst_n is synchronous, active low; clears parser state, tag pointers and queue,
//   loads max_unit_len with 1048576. Tag RAM contents are not cleared; no sweep is needed.
//
// Top level of the length-prefixed unit deframer. Depends on nldt_pkg,
// nldt_front, nldt_queue and nldt_back.
module nal_length_deframer_with_tags_top #(
  parameter int TAG_DEPTH = nldt_pkg::TAG_DEPTH_DEF,
  parameter int TAG_WIDTH = nldt_pkg::TAG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write request
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_max_unit_len,
  // input requests
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [7:0]           in_in_byte,
  input  logic                 in_chunk_start,
  input  logic [TAG_WIDTH-1:0] in_tag_in,
  // result requests
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_byte_valid,
  output logic [7:0]           out_out_byte,
  output logic                 out_first_of_unit,
  output logic                 out_last_of_unit,
  output logic [31:0]          out_unit_length,
  output logic [5:0]           out_unit_type,
  output logic [TAG_WIDTH-1:0] out_tag_out,
  output logic                 out_tag_valid,
  output logic [2:0]           out_status
);

  // front -> queue
  logic                 q_push;
  nldt_pkg::req_t       q_req;
  logic [TAG_WIDTH-1:0] q_tag;
  logic                 q_full;
  // queue -> back
  logic                 q_pop;
  logic                 head_valid;
  nldt_pkg::req_t       head_req;
  logic [TAG_WIDTH-1:0] head_tag;
  // back -> ports
  nldt_pkg::req_t       res;

  // Accept while the queue has room; the back end drains one request a cycle,
  // so the queue never fills unless the result side stalls.
  assign in_ready = !q_full;

  // Front: limit register, header/payload/discard parsing, request classification
  nldt_front #(
    .TAG_WIDTH (TAG_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_unit_len (cfg_max_unit_len),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_in_byte       (in_in_byte),
    .in_chunk_start   (in_chunk_start),
    .in_tag_in        (in_tag_in),
    .q_push           (q_push),
    .q_req            (q_req),
    .q_tag            (q_tag)
  );

  // Queue: decouple parsing from tag handling and result stalls
  nldt_queue #(
    .TAG_WIDTH (TAG_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_req   (q_req),
    .push_tag   (q_tag),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_req   (head_req),
    .head_tag   (head_tag)
  );

  // Back: push or pop tags in request order, hold the result register
  nldt_back #(
    .TAG_DEPTH (TAG_DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_req   (head_req),
    .head_tag   (head_tag),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res),
    .res_tvalid (out_tag_valid),
    .res_tag    (out_tag_out)
  );

  // Unpack the result register onto the ports
  assign out_byte_valid    = res.byte_valid;
  assign out_out_byte      = res.out_byte;
  assign out_first_of_unit = res.first_of_unit;
  assign out_last_of_unit  = res.last_of_unit;
  assign out_unit_length   = res.unit_length;
  assign out_unit_type     = res.unit_type;
  assign out_status        = res.status;

endmodule

### rtl/core/nldt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nldt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/nldt_front.sv
// Front end: holds the limit register, parses the byte stream and classifies requests.
// Depends on nldt_pkg.
module nldt_front #(
  parameter int TAG_WIDTH = nldt_pkg::TAG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_max_unit_len,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_operation,
  input  logic [7:0]           in_in_byte,
  input  logic                 in_chunk_start,
  input  logic [TAG_WIDTH-1:0] in_tag_in,
  output logic                 q_push,
  output nldt_pkg::req_t       q_req,
  output logic [TAG_WIDTH-1:0] q_tag
);

  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_PAYLOAD = 2'd1;
  localparam logic [1:0] MODE_DISCARD = 2'd2;
  localparam logic [1:0] HDR_LAST     = 2'd3;

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  hc_r, hc_nxt;
  logic [31:0] lw_r, lw_nxt;
  logic [31:0] bl_r, bl_nxt;
  logic [5:0]  ct_r, ct_nxt;
  logic [31:0] ulen_r, ulen_nxt;
  logic [31:0] max_r;

  logic        hdr;
  logic [1:0]  hc_eff;
  logic [31:0] lw_cat;
  logic [32:0] sum;
  logic [31:0] ulen_sat;
  logic [5:0]  ct_new;
  logic [31:0] bl_dec;
  logic [7:0]  type_bits;

  assign cfg_ready = 1'b1;
  assign q_push    = in_valid && in_ready;
  assign q_tag     = in_tag_in;
  assign type_bits = in_in_byte & nldt_pkg::TYPE_MASK;

  always_comb begin
    mode_nxt = mode_r;
    hc_nxt   = hc_r;
    lw_nxt   = lw_r;
    bl_nxt   = bl_r;
    ct_nxt   = ct_r;
    ulen_nxt = ulen_r;
    q_req    = '0;
    hdr      = (mode_r == MODE_HEADER);
    hc_eff   = hc_r;
    lw_cat   = {((hc_r == 2'd0) ? 24'd0 : lw_r[23:0]), in_in_byte};
    sum      = {1'b0, lw_cat} + 33'd4;
    ulen_sat = sum[32] ? 32'hffff_ffff : sum[31:0];
    ct_new   = (bl_r == lw_r) ? type_bits[6:1] : ct_r;
    bl_dec   = bl_r - 32'd1;
    if (in_operation == nldt_pkg::OP_PUSH) begin
      q_req.kind = nldt_pkg::KIND_PUSH;
    end else begin
      q_req.kind = nldt_pkg::KIND_BYTE;
      if (mode_r == MODE_DISCARD) begin
        // resync on chunk start, otherwise drop the byte
        if (in_chunk_start) begin
          hdr      = 1'b1;
          hc_eff   = 2'd0;
          mode_nxt = MODE_HEADER;
          lw_cat   = {24'd0, in_in_byte};
          sum      = {1'b0, lw_cat} + 33'd4;
          ulen_sat = sum[32] ? 32'hffff_ffff : sum[31:0];
        end else begin
          q_req.status = nldt_pkg::ST_DISCARD;
        end
      end
      if (hdr) begin
        q_req.byte_valid    = 1'b1;
        q_req.out_byte      = in_in_byte;
        q_req.first_of_unit = (hc_eff == 2'd0);
        lw_nxt              = lw_cat;
        if (hc_eff == HDR_LAST) begin
          hc_nxt            = 2'd0;
          ulen_nxt          = ulen_sat;
          q_req.unit_length = ulen_sat;
          if (sum > {1'b0, max_r}) begin
            q_req.status = nldt_pkg::ST_OVERSIZE;
            mode_nxt     = MODE_DISCARD;
          end else if (lw_cat == 32'd0) begin
            // empty payload: unit ends here, no tag
            q_req.last_of_unit = 1'b1;
          end else begin
            bl_nxt   = lw_cat;
            mode_nxt = MODE_PAYLOAD;
          end
        end else begin
          hc_nxt = hc_eff + 2'd1;
        end
      end else if (mode_r == MODE_PAYLOAD) begin
        q_req.byte_valid  = 1'b1;
        q_req.out_byte    = in_in_byte;
        q_req.unit_length = ulen_r;
        ct_nxt            = ct_new;
        bl_nxt            = bl_dec;
        if (bl_dec == 32'd0) begin
          q_req.last_of_unit = 1'b1;
          q_req.unit_type    = ct_new;
          mode_nxt           = MODE_HEADER;
          hc_nxt             = 2'd0;
          if (nldt_pkg::is_picture(ct_new)) begin
            q_req.kind = nldt_pkg::KIND_POP;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HEADER;
      hc_r   <= 2'd0;
      lw_r   <= 32'd0;
      bl_r   <= 32'd0;
      ct_r   <= 6'd0;
      ulen_r <= 32'd0;
      max_r  <= nldt_pkg::MAX_LEN_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_max_unit_len;
      end
      if (q_push) begin
        mode_r <= mode_nxt;
        hc_r   <= hc_nxt;
        lw_r   <= lw_nxt;
        bl_r   <= bl_nxt;
        ct_r   <= ct_nxt;
        ulen_r <= ulen_nxt;
      end
    end
  end

endmodule

### rtl/core/nldt_queue.sv
// Two-entry request queue between the parser front and the tag back end.
// Depends on nldt_pkg.
module nldt_queue #(
  parameter int TAG_WIDTH = nldt_pkg::TAG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  nldt_pkg::req_t       push_req,
  input  logic [TAG_WIDTH-1:0] push_tag,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output nldt_pkg::req_t       head_req,
  output logic [TAG_WIDTH-1:0] head_tag
);

  nldt_pkg::req_t       req_q [2];
  logic [TAG_WIDTH-1:0] tag_q [2];
  logic                 wp_r, rp_r;
  logic [1:0]           cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_req   = req_q[rp_r];
  assign head_tag   = tag_q[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      req_q[wp_r] <= push_req;
      tag_q[wp_r] <= push_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/core/nldt_back.sv
// Back end: tag FIFO control over the tag RAM and the output register.
// Depends on nldt_pkg and nldt_ram.
module nldt_back #(
  parameter int TAG_DEPTH = nldt_pkg::TAG_DEPTH_DEF,
  parameter int TAG_WIDTH = nldt_pkg::TAG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  nldt_pkg::req_t       head_req,
  input  logic [TAG_WIDTH-1:0] head_tag,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nldt_pkg::req_t       res,
  output logic                 res_tvalid,
  output logic [TAG_WIDTH-1:0] res_tag
);

  localparam int             AW       = $clog2(TAG_DEPTH);
  localparam logic [AW-1:0]  LAST_IDX = AW'(TAG_DEPTH - 1);

  logic [AW-1:0]        wr_idx_r, rd_idx_r;
  logic                 wr_lap_r, rd_lap_r;
  logic                 res_valid_r;
  nldt_pkg::req_t       res_r, res_nxt;
  logic                 tv_r, tv_nxt;
  logic                 tq_full, tq_empty;
  logic                 we, re;
  logic [TAG_WIDTH-1:0] rdata;

  assign tq_full  = (wr_idx_r == rd_idx_r) && (wr_lap_r != rd_lap_r);
  assign tq_empty = (wr_idx_r == rd_idx_r) && (wr_lap_r == rd_lap_r);
  assign pop      = head_valid && (!res_valid_r || out_ready);

  always_comb begin
    res_nxt = head_req;
    tv_nxt  = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    case (head_req.kind)
      nldt_pkg::KIND_PUSH: begin
        if (tq_full) begin
          res_nxt.status = nldt_pkg::ST_TAG_DROP;
        end else begin
          we = pop;
        end
      end
      nldt_pkg::KIND_POP: begin
        if (tq_empty) begin
          res_nxt.status = nldt_pkg::ST_NO_TAG;
        end else begin
          re     = pop;
          tv_nxt = 1'b1;
        end
      end
      nldt_pkg::KIND_BYTE: begin
      end
      default: begin
      end
    endcase
  end

  nldt_ram #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_idx_r),
    .wdata (head_tag),
    .re    (re),
    .raddr (rd_idx_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      wr_lap_r    <= 1'b0;
      rd_lap_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (we) begin
        wr_idx_r <= (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
        wr_lap_r <= (wr_idx_r == LAST_IDX) ? ~wr_lap_r : wr_lap_r;
      end
      if (re) begin
        rd_idx_r <= (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
        rd_lap_r <= (rd_idx_r == LAST_IDX) ? ~rd_lap_r : rd_lap_r;
      end
      if (pop) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
      tv_r  <= tv_nxt;
    end
  end

  assign out_valid  = res_valid_r;
  assign res        = res_r;
  assign res_tvalid = tv_r;
  // RAM read data holds until the next pop, which waits for this result
  assign res_tag    = tv_r ? rdata : '0;

endmodule

### rtl/core/nldt_checker.sv
// Port-level checker for the deframer top level, attached by bind below.
// Depends on nldt_pkg and nal_length_deframer_with_tags_top.
module nldt_checker #(
  parameter int TAG_WIDTH = nldt_pkg::TAG_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [31:0]          cfg_max_unit_len,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_operation,
  input logic [7:0]           in_in_byte,
  input logic                 in_chunk_start,
  input logic [TAG_WIDTH-1:0] in_tag_in,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_byte_valid,
  input logic [7:0]           out_out_byte,
  input logic                 out_first_of_unit,
  input logic                 out_last_of_unit,
  input logic [31:0]          out_unit_length,
  input logic [5:0]           out_unit_type,
  input logic [TAG_WIDTH-1:0] out_tag_out,
  input logic                 out_tag_valid,
  input logic [2:0]           out_status
);

  // a popped tag only comes with the last byte of a unit
  a_tag_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tag_valid) |-> (out_byte_valid && out_last_of_unit))
    else $error("tag given outside a unit's last byte");

  // a result without a byte carries no byte and no marks
  a_no_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |->
      (out_out_byte == 8'd0 && !out_first_of_unit && !out_last_of_unit))
    else $error("non-byte result carries byte fields");

  // missing tag is reported only at a unit end with no tag given
  a_no_tag_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == nldt_pkg::ST_NO_TAG) |->
      (out_last_of_unit && !out_tag_valid))
    else $error("no-tag status on wrong result");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("stalled result dropped or changed");

endmodule

bind nal_length_deframer_with_tags_top nldt_checker #(.TAG_WIDTH(TAG_WIDTH)) u_nldt_checker (.*);
